// ===== rtl/core/tem_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tem_pkg
// Shared widths, constants and beat types of the triangle element matrices
// unit.
// ============================================================================
package tem_pkg;

  // Default coordinate width taken from each vertex field
  localparam int TEM_COORD_WIDTH = 32;

  // Fixed datapath widths
  localparam int FIELD_W = 32;   // input field width
  localparam int DIFF_W  = 33;   // coordinate difference
  localparam int PROD_W  = 66;   // product of two differences
  localparam int AREA_W  = 67;   // doubled area, Q32.32
  localparam int ZM_W    = 50;   // mass quotient before the divide by three
  localparam int SMAG_W  = 65;   // magnitude of ai*aj + bi*bj
  localparam int NUM_W   = 97;   // stiffness dividend
  localparam int DEN_W   = 68;   // stiffness divisor, 2|D|
  localparam int QUO_W   = 33;   // stiffness quotient bits kept
  localparam int MASS_W  = 31;   // mass entry width

  // Queue depths (powers of two)
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  // Divide by three through a reciprocal, exact for values below 2^33
  localparam logic [32:0]       DIV3_MAGIC  = 33'h155555556;
  localparam int                DIV3_SHIFT  = 34;
  localparam logic [ZM_W-1:0]   MASS_Z_LIM  = 50'h180000000;
  localparam logic [MASS_W-1:0] MASS_MAX    = 31'h7FFFFFFF;
  localparam logic [ZM_W+2:0]   MASS_HALF   = 53'd12;

  // Stiffness saturation bounds
  localparam logic [QUO_W-1:0]   STIFF_POS_LIM = 33'h07FFFFFFF;
  localparam logic [QUO_W-1:0]   STIFF_NEG_LIM = 33'h080000000;
  localparam logic [FIELD_W-1:0] STIFF_POS_MAX = 32'h7FFFFFFF;
  localparam logic [FIELD_W-1:0] STIFF_NEG_MAG = 32'h80000000;

  localparam logic [1:0] IDX_LAST = 2'd2;

  // One classified triangle, handed from the front to the back
  typedef struct packed {
    logic [2:0][DIFF_W-1:0] a;
    logic [2:0][DIFF_W-1:0] b;
    logic [FIELD_W-1:0]     cmag;
    logic                   cneg;
    logic [AREA_W-1:0]      absd;
    logic                   sing;
    logic [MASS_W-1:0]      mdiag;
    logic [MASS_W-1:0]      moff;
  } tem_desc_t;

  // Per-entry control traveling with the stiffness datapath
  typedef struct packed {
    logic [1:0]        row;
    logic [1:0]        col;
    logic              last;
    logic              sing;
    logic              neg;
    logic [MASS_W-1:0] mass;
  } tem_tag_t;

  // One result beat
  typedef struct packed {
    logic [1:0]         row;
    logic [1:0]         col;
    logic [FIELD_W-1:0] stiff;
    logic [MASS_W-1:0]  mass;
    logic               sing;
    logic               last;
  } tem_res_t;

endpackage

// ===== rtl/core/triangle_element_matrices_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// triangle_element_matrices_unit
// Local stiffness and mass matrices of a linear triangle, Q16.16.
// ============================================================================
// Usage:
//   Input queue: drive the seven in_* fields with push high; a triangle is
//   taken at a clock edge where push is high and full is low.
//   Result queue: while empty is low the oldest entry is on the out_* ports;
//   pop high at an edge takes it. Entries come in row-major order, nine per
//   triangle with last on the ninth; a singular triangle gives one entry
//   with singular and last set and zero values.
//   Configuration: cfg_data is written to singular_limit when cfg_valid is
//   high (cfg_ready is always high). Write only while the block is idle.
//   Throughput: one entry per cycle while the result queue is not full, set
//   by the entry sequencer feeding the 33-stage pipelined divider; a regular
//   triangle gives nine entries and a singular one gives one. The front
//   part keeps taking triangles while the back part works, up to a
//   four-deep triangle queue.
//   When pop is held low the two-entry result queue fills, the back pipeline
//   freezes, then the triangle queue and the front fill and full rises.
//   Reset empties every queue and clears singular_limit to zero.
// ============================================================================
module triangle_element_matrices_unit
  import tem_pkg::*;
#(
  parameter int COORD_WIDTH = TEM_COORD_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // input queue
  input  logic               push,
  output logic               full,
  input  logic [FIELD_W-1:0] in_vertex0_x,
  input  logic [FIELD_W-1:0] in_vertex0_y,
  input  logic [FIELD_W-1:0] in_vertex1_x,
  input  logic [FIELD_W-1:0] in_vertex1_y,
  input  logic [FIELD_W-1:0] in_vertex2_x,
  input  logic [FIELD_W-1:0] in_vertex2_y,
  input  logic [FIELD_W-1:0] in_stiffness_coef,
  // result queue
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_row,
  output logic [1:0]         out_col,
  output logic [FIELD_W-1:0] out_stiffness_entry,
  output logic [MASS_W-1:0]  out_mass_entry,
  output logic               out_singular,
  output logic               out_last,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [FIELD_W-1:0] cfg_data
);

  localparam int DESC_W = $bits(tem_desc_t);
  localparam int RES_W  = $bits(tem_res_t);

  logic [FIELD_W-1:0] lim_r;
  logic               mb_push, mb_full, mb_empty, mb_pop;
  logic               ob_push, ob_full;
  tem_desc_t          fr_desc, mb_head;
  tem_res_t           bk_res, ob_head;
  logic [DESC_W-1:0]  mb_head_bits;
  logic [RES_W-1:0]   ob_head_bits;

  // Hold the singular limit
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      lim_r <= cfg_data;
    end
  end

  tem_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (push),
    .in_full   (full),
    .v0x       (in_vertex0_x),
    .v0y       (in_vertex0_y),
    .v1x       (in_vertex1_x),
    .v1y       (in_vertex1_y),
    .v2x       (in_vertex2_x),
    .v2y       (in_vertex2_y),
    .coef      (in_stiffness_coef),
    .lim       (lim_r),
    .mid_full  (mb_full),
    .desc_push (mb_push),
    .desc      (fr_desc)
  );

  // Triangle queue between front and back
  tem_fifo #(
    .WIDTH (DESC_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mb_push),
    .push_data (fr_desc),
    .pop       (mb_pop),
    .pop_data  (mb_head_bits),
    .full      (mb_full),
    .empty     (mb_empty)
  );

  assign mb_head = mb_head_bits;

  tem_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc       (mb_head),
    .desc_empty (mb_empty),
    .desc_pop   (mb_pop),
    .res_full   (ob_full),
    .res_push   (ob_push),
    .res        (bk_res)
  );

  // Result queue
  tem_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ob_push),
    .push_data (bk_res),
    .pop       (pop),
    .pop_data  (ob_head_bits),
    .full      (ob_full),
    .empty     (empty)
  );

  assign ob_head             = ob_head_bits;
  assign out_row             = ob_head.row;
  assign out_col             = ob_head.col;
  assign out_stiffness_entry = ob_head.stiff;
  assign out_mass_entry      = ob_head.mass;
  assign out_singular        = ob_head.sing;
  assign out_last            = ob_head.last;

`ifndef SYNTHESIS
  // The back pipeline never writes a full result queue
  a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ob_push |-> !ob_full) else $error("result queue overrun");

  // The front never writes a full triangle queue
  a_mid_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    mb_push |-> !mb_full) else $error("triangle queue overrun");

  // Entry position stays inside the 3x3 matrix
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_row != 2'd3 && out_col != 2'd3)) else $error("entry index out of range");

  // A singular beat is the only beat of its triangle
  a_sing_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_singular) |-> (out_last && out_row == 2'd0 && out_col == 2'd0))
    else $error("singular beat not alone");
`endif

endmodule

// ===== rtl/core/tem_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tem_fifo
// Small register queue with the head shown while not empty. DEPTH must be a
// power of two.
// ============================================================================
module tem_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rp_r];

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/tem_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tem_front
// Accept triangles, form edge terms and doubled area, classify singular
// triangles and work out both mass values.
// ============================================================================
module tem_front
  import tem_pkg::*;
#(
  parameter int COORD_WIDTH = TEM_COORD_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [FIELD_W-1:0] v0x,
  input  logic [FIELD_W-1:0] v0y,
  input  logic [FIELD_W-1:0] v1x,
  input  logic [FIELD_W-1:0] v1y,
  input  logic [FIELD_W-1:0] v2x,
  input  logic [FIELD_W-1:0] v2y,
  input  logic [FIELD_W-1:0] coef,
  input  logic [FIELD_W-1:0] lim,
  input  logic               mid_full,
  output logic               desc_push,
  output tem_desc_t          desc
);

  localparam int CW_EFF = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int SH     = FIELD_W - CW_EFF;

  // Keep the low coordinate bits, sign-extended, widened by one bit
  function automatic logic signed [DIFF_W-1:0] coord(input logic [FIELD_W-1:0] v);
    logic signed [FIELD_W-1:0] t;
    t = $signed(v << SH);
    t = t >>> SH;
    return $signed({t[FIELD_W-1], t});
  endfunction

  logic       adv, acc;
  logic [7:1] vld_r;

  logic signed [DIFF_W-1:0] x0, y0, x1, y1, x2, y2;
  logic signed [DIFF_W-1:0] dx1_r, dy2_r, dx2_r, dy1_r;
  logic signed [PROD_W-1:0] p1_r, p2_r;
  logic signed [AREA_W-1:0] d_r;
  logic [ZM_W-1:0]          zd_r, zo_r;
  logic [PROD_W-1:0]        qd_r, qo_r;
  logic                     sd_r, so_r;
  logic [FIELD_W-1:0]       cmag;
  tem_desc_t                st_r [1:7];
  tem_desc_t                st1_nxt, st4_nxt, st5_nxt, st7_nxt;

  assign adv       = !(vld_r[7] && mid_full);
  assign acc       = in_push && adv;
  assign in_full   = !adv;
  assign desc_push = vld_r[7] && adv;
  assign desc      = st_r[7];

  assign x0   = coord(v0x);
  assign y0   = coord(v0y);
  assign x1   = coord(v1x);
  assign y1   = coord(v1y);
  assign x2   = coord(v2x);
  assign y2   = coord(v2y);
  assign cmag = coef[FIELD_W-1] ? (~coef + FIELD_W'(1)) : coef;

  // Build the descriptor updates of the stages that change a field
  always_comb begin
    // edge terms and coefficient
    st1_nxt      = '0;
    st1_nxt.a[0] = y1 - y2;
    st1_nxt.a[1] = y2 - y0;
    st1_nxt.a[2] = y0 - y1;
    st1_nxt.b[0] = x2 - x1;
    st1_nxt.b[1] = x0 - x2;
    st1_nxt.b[2] = x1 - x0;
    st1_nxt.cmag = cmag;
    st1_nxt.cneg = coef[FIELD_W-1];
    // magnitude of the area
    st4_nxt      = st_r[3];
    st4_nxt.absd = d_r[AREA_W-1] ? AREA_W'(-d_r) : AREA_W'(d_r);
    // singular test
    st5_nxt      = st_r[4];
    st5_nxt.sing = (st_r[4].absd <= AREA_W'({lim, 16'h0000}));
    // final mass values
    st7_nxt       = st_r[6];
    st7_nxt.mdiag = sd_r ? MASS_MAX : qd_r[DIV3_SHIFT +: MASS_W];
    st7_nxt.moff  = so_r ? MASS_MAX : qo_r[DIV3_SHIFT +: MASS_W];
  end

  // Advance the valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[6:1], acc};
    end
  end

  // Run the front stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // differences and edge terms
      dx1_r   <= x1 - x0;
      dy2_r   <= y2 - y0;
      dx2_r   <= x2 - x0;
      dy1_r   <= y1 - y0;
      st_r[1] <= st1_nxt;
      // cross products
      p1_r    <= dx1_r * dy2_r;
      p2_r    <= dx2_r * dy1_r;
      st_r[2] <= st_r[1];
      // doubled area
      d_r     <= $signed({p1_r[PROD_W-1], p1_r}) - $signed({p2_r[PROD_W-1], p2_r});
      st_r[3] <= st_r[2];
      // magnitude of the area
      st_r[4] <= st4_nxt;
      // singular test and mass rounding
      st_r[5] <= st5_nxt;
      zd_r    <= ZM_W'((53'(st_r[4].absd[AREA_W-1:15]) + MASS_HALF) >> 3);
      zo_r    <= ZM_W'((53'(st_r[4].absd[AREA_W-1:16]) + MASS_HALF) >> 3);
      // divide by three and flag saturation
      st_r[6] <= st_r[5];
      qd_r    <= zd_r[32:0] * DIV3_MAGIC;
      qo_r    <= zo_r[32:0] * DIV3_MAGIC;
      sd_r    <= (zd_r >= MASS_Z_LIM);
      so_r    <= (zo_r >= MASS_Z_LIM);
      // final mass values
      st_r[7] <= st7_nxt;
    end
  end

endmodule

// ===== rtl/core/tem_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tem_div
// Pipelined restoring divider: one quotient bit per stage, with an overflow
// flag for quotients past the kept bits.
// ============================================================================
module tem_div
  import tem_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  tem_tag_t         tag,
  output logic             out_vld,
  output logic [QUO_W-1:0] quo,
  output logic             ovf,
  output tem_tag_t         out_tag
);

  localparam int CMP_W = DEN_W + QUO_W;

  logic             vld_r [0:QUO_W];
  logic [NUM_W-1:0] rem_r [0:QUO_W];
  logic [DEN_W-1:0] den_r [0:QUO_W];
  logic [QUO_W-1:0] quo_r [0:QUO_W];
  logic             ovf_r [0:QUO_W];
  tem_tag_t         tag_r [0:QUO_W];

  assign out_vld = vld_r[QUO_W];
  assign quo     = quo_r[QUO_W];
  assign ovf     = ovf_r[QUO_W];
  assign out_tag = tag_r[QUO_W];

  // Load the dividend
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      quo_r[0] <= '0;
      ovf_r[0] <= 1'b0;
      tag_r[0] <= tag;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
    localparam int T = QUO_W - s;
    logic [CMP_W-1:0] rem_x, sub_x, dif_x;
    logic             ge;

    assign rem_x = CMP_W'(rem_r[s-1]);
    assign sub_x = CMP_W'(den_r[s-1]) << T;
    assign ge    = (rem_x >= sub_x);
    assign dif_x = rem_x - sub_x;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? dif_x[NUM_W-1:0] : rem_r[s-1];
        den_r[s] <= den_r[s-1];
        quo_r[s] <= quo_r[s-1] | (QUO_W'(ge) << T);
        tag_r[s] <= tag_r[s-1];
        if (s == 1) begin
          ovf_r[s] <= (rem_x >= (CMP_W'(den_r[s-1]) << QUO_W));
        end else begin
          ovf_r[s] <= ovf_r[s-1];
        end
      end
    end
  end

endmodule

// ===== rtl/core/tem_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tem_back
// Walk each triangle's entries (nine, one if singular), form the stiffness
// dividend and divide, then saturate and hand each entry to the result queue.
// ============================================================================
module tem_back
  import tem_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tem_desc_t desc,
  input  logic      desc_empty,
  output logic      desc_pop,
  input  logic      res_full,
  output logic      res_push,
  output tem_res_t  res
);

  logic      en, last_issue;
  logic      busy_r;
  logic [1:0] row_r, col_r;
  tem_desc_t cur_r;

  logic                     e0_vld_r, e1_vld_r, e2_vld_r, e3_vld_r, e4_vld_r;
  tem_tag_t                 e0_tag_r, e1_tag_r, e2_tag_r, e3_tag_r, e4_tag_r;
  logic signed [DIFF_W-1:0] ai_r, aj_r, bi_r, bj_r;
  logic signed [PROD_W-1:0] pa_r, pb_r;
  logic signed [AREA_W-1:0] s_r;
  logic [SMAG_W-1:0]        smag_r;
  logic [63:0]              pl_r;
  logic [SMAG_W-1:0]        ph_r;
  logic [FIELD_W-1:0]       cm0_r, cm1_r, cm2_r, cm3_r;
  logic                     cn0_r, cn1_r, cn2_r;
  logic [AREA_W-1:0]        ad0_r, ad1_r, ad2_r, ad3_r, ad4_r;
  logic [NUM_W-1:0]         num;
  logic [DEN_W-1:0]         den;

  logic             dv_vld, dv_ovf, big;
  logic [QUO_W-1:0] dv_quo;
  tem_tag_t         dv_tag;
  logic [FIELD_W-1:0] mag;

  assign en         = !res_full;
  assign last_issue = busy_r && (cur_r.sing || (row_r == IDX_LAST && col_r == IDX_LAST));
  assign desc_pop   = en && !desc_empty && (!busy_r || last_issue);

  // Sequence entries of the current triangle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= '0;
      col_r  <= '0;
    end else if (en) begin
      if (desc_pop) begin
        busy_r <= 1'b1;
        row_r  <= '0;
        col_r  <= '0;
      end else if (last_issue) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        if (col_r == IDX_LAST) begin
          col_r <= '0;
          row_r <= row_r + 2'd1;
        end else begin
          col_r <= col_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && desc_pop) begin
      cur_r <= desc;
    end
  end

  // Advance the entry valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_vld_r <= 1'b0;
      e1_vld_r <= 1'b0;
      e2_vld_r <= 1'b0;
      e3_vld_r <= 1'b0;
      e4_vld_r <= 1'b0;
    end else if (en) begin
      e0_vld_r <= busy_r;
      e1_vld_r <= e0_vld_r;
      e2_vld_r <= e1_vld_r;
      e3_vld_r <= e2_vld_r;
      e4_vld_r <= e3_vld_r;
    end
  end

  // Entry datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // issue: pick the operands of this entry
      e0_tag_r.row  <= row_r;
      e0_tag_r.col  <= col_r;
      e0_tag_r.last <= last_issue;
      e0_tag_r.sing <= cur_r.sing;
      e0_tag_r.neg  <= 1'b0;
      e0_tag_r.mass <= (row_r == col_r) ? cur_r.mdiag : cur_r.moff;
      ai_r  <= $signed(cur_r.a[row_r]);
      aj_r  <= $signed(cur_r.a[col_r]);
      bi_r  <= $signed(cur_r.b[row_r]);
      bj_r  <= $signed(cur_r.b[col_r]);
      cm0_r <= cur_r.cmag;
      cn0_r <= cur_r.cneg;
      ad0_r <= cur_r.absd;
      // gradient products
      e1_tag_r <= e0_tag_r;
      pa_r  <= ai_r * aj_r;
      pb_r  <= bi_r * bj_r;
      cm1_r <= cm0_r;
      cn1_r <= cn0_r;
      ad1_r <= ad0_r;
      // sum
      e2_tag_r <= e1_tag_r;
      s_r   <= $signed({pa_r[PROD_W-1], pa_r}) + $signed({pb_r[PROD_W-1], pb_r});
      cm2_r <= cm1_r;
      cn2_r <= cn1_r;
      ad2_r <= ad1_r;
      // magnitude and result sign
      e3_tag_r <= {e2_tag_r.row, e2_tag_r.col, e2_tag_r.last, e2_tag_r.sing,
                   s_r[AREA_W-1] ^ cn2_r, e2_tag_r.mass};
      smag_r <= s_r[AREA_W-1] ? SMAG_W'(-s_r) : SMAG_W'(s_r);
      cm3_r  <= cm2_r;
      ad3_r  <= ad2_r;
      // coefficient product in two halves
      e4_tag_r <= e3_tag_r;
      pl_r  <= smag_r[31:0] * cm3_r;
      ph_r  <= smag_r[SMAG_W-1:32] * cm3_r;
      ad4_r <= ad3_r;
    end
  end

  // Dividend |s|*|c| + |D| for round to nearest, divisor 2|D|
  assign num = NUM_W'({ph_r, 32'h0}) + NUM_W'(pl_r) + NUM_W'(ad4_r);
  assign den = {ad4_r, 1'b0};

  tem_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (e4_vld_r),
    .num     (num),
    .den     (den),
    .tag     (e4_tag_r),
    .out_vld (dv_vld),
    .quo     (dv_quo),
    .ovf     (dv_ovf),
    .out_tag (dv_tag)
  );

  // Saturate and build the result beat
  always_comb begin
    big = dv_ovf || (dv_tag.neg ? (dv_quo > STIFF_NEG_LIM) : (dv_quo > STIFF_POS_LIM));
    if (dv_tag.neg) begin
      mag = big ? STIFF_NEG_MAG : dv_quo[FIELD_W-1:0];
    end else begin
      mag = big ? STIFF_POS_MAX : dv_quo[FIELD_W-1:0];
    end
    res.row  = dv_tag.row;
    res.col  = dv_tag.col;
    res.sing = dv_tag.sing;
    res.last = dv_tag.last;
    if (dv_tag.sing) begin
      res.stiff = '0;
      res.mass  = '0;
    end else begin
      res.stiff = dv_tag.neg ? (~mag + FIELD_W'(1)) : mag;
      res.mass  = dv_tag.mass;
    end
  end

  assign res_push = en && dv_vld;

endmodule
